@@ src/pow2_bucket_block_allocator_top_assert.svh @@
// Assertion macros for the pow2 bucket block allocator.
// Used by modules that check their own sequencing; expects i_clk and i_rst_n in scope.
`ifndef POW2_BUCKET_BLOCK_ALLOCATOR_TOP_ASSERT_SVH
`define POW2_BUCKET_BLOCK_ALLOCATOR_TOP_ASSERT_SVH

// same-cycle implication
`define PBA_ASSERT_NOW(label, ante, cons) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error("pba assertion failed");

// next-cycle implication
`define PBA_ASSERT_NEXT(label, ante, cons) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error("pba assertion failed");

`endif

@@ src/pba_pkg.sv @@
// Shared types, constants and helper functions of the pow2 bucket block allocator.
// No dependencies.
`timescale 1ns / 1ps
`default_nettype none

package pba_pkg;

    localparam int SIZE_CLASSES = 8;
    localparam int HEADER_WORDS = 16384;
    localparam int MIN_BLOCK    = 8;
    localparam int HDR_BYTES    = 4;

    localparam int ADDR_W = 16;
    localparam int BRK_W  = ADDR_W + 1;
    localparam int CLS_W  = $clog2(SIZE_CLASSES);
    localparam int HDR_AW = $clog2(HEADER_WORDS);

    localparam int QDEPTH = 2;
    localparam int QAW    = $clog2(QDEPTH);
    localparam int QCW    = $clog2(QDEPTH + 1);

    typedef logic [ADDR_W-1:0] t_addr;
    typedef logic [BRK_W-1:0]  t_brk;
    typedef logic [CLS_W-1:0]  t_cls;
    typedef logic [HDR_AW-1:0] t_hdr_idx;
    typedef logic [QAW-1:0]    t_qptr;
    typedef logic [QCW-1:0]    t_qcnt;

    typedef enum logic {
        OP_ALLOC = 1'b0,
        OP_FREE  = 1'b1
    } t_op;

    typedef enum logic [1:0] {
        ST_OK        = 2'd0,
        ST_BAD_SIZE  = 2'd1,
        ST_EXHAUSTED = 2'd2
    } t_status;

    typedef enum logic {
        CFG_HEAP_BASE  = 1'b0,
        CFG_HEAP_LIMIT = 1'b1
    } t_cfg_idx;

    // classified request, front to back
    typedef struct packed {
        t_op   op;
        logic  size_ok;
        t_cls  cls;
        t_addr addr;
    } t_cmd;

    // result, back to result queue
    typedef struct packed {
        t_addr   addr;
        t_status status;
    } t_res;

    function automatic t_brk class_bytes(input t_cls c);
        return t_brk'(MIN_BLOCK << c);
    endfunction

    // header word of a usable address
    function automatic t_hdr_idx hdr_index(input t_addr usable);
        t_addr blk;
        blk = usable - t_addr'(HDR_BYTES);
        return t_hdr_idx'((32'(blk) >> 2) % HEADER_WORDS);
    endfunction

endpackage

`default_nettype wire

@@ src/pba_front.sv @@
// Front end: classifies each request by size class and holds it in a short queue.
// Depends on pba_pkg.
`timescale 1ns / 1ps
`default_nettype none

module pba_front (
    input  wire                  i_clk,
    input  wire                  i_rst_n,
    input  wire                  i_push,
    output logic                 o_full,
    input  wire                  i_opcode,
    input  wire  [15:0]          i_request_size,
    input  wire  [15:0]          i_release_address,
    output logic                 o_cmd_valid,
    output pba_pkg::t_cmd        o_cmd,
    input  wire                  i_cmd_pop
);

    pba_pkg::t_cmd  r_q [pba_pkg::QDEPTH];
    pba_pkg::t_qptr r_wp, n_wp;
    pba_pkg::t_qptr r_rp, n_rp;
    pba_pkg::t_qcnt r_cnt, n_cnt;
    pba_pkg::t_cmd  cmd_in;
    logic           do_push;
    logic           do_pop;

    // smallest class that holds the size
    always_comb begin
        cmd_in.op      = pba_pkg::t_op'(i_opcode);
        cmd_in.addr    = i_release_address;
        cmd_in.size_ok = 1'b0;
        cmd_in.cls     = '0;
        for (int c = pba_pkg::SIZE_CLASSES - 1; c >= 0; c--) begin
            if (32'(pba_pkg::MIN_BLOCK << c) >= 32'(i_request_size)) begin
                cmd_in.cls     = pba_pkg::t_cls'(c);
                cmd_in.size_ok = (i_request_size != '0);
            end
        end
    end

    assign o_full      = (r_cnt == pba_pkg::t_qcnt'(pba_pkg::QDEPTH));
    assign o_cmd_valid = (r_cnt != '0);
    assign o_cmd       = r_q[r_rp];
    assign do_push     = i_push && !o_full;
    assign do_pop      = i_cmd_pop && o_cmd_valid;

    always_comb begin
        n_wp  = r_wp;
        n_rp  = r_rp;
        n_cnt = r_cnt;
        if (do_push) begin
            n_wp = (r_wp == pba_pkg::t_qptr'(pba_pkg::QDEPTH - 1)) ? '0 : r_wp + 1'b1;
        end
        if (do_pop) begin
            n_rp = (r_rp == pba_pkg::t_qptr'(pba_pkg::QDEPTH - 1)) ? '0 : r_rp + 1'b1;
        end
        if (do_push && !do_pop) begin
            n_cnt = r_cnt + 1'b1;
        end else if (do_pop && !do_push) begin
            n_cnt = r_cnt - 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wp  <= '0;
            r_rp  <= '0;
            r_cnt <= '0;
        end else begin
            r_wp  <= n_wp;
            r_rp  <= n_rp;
            r_cnt <= n_cnt;
        end
    end

    always_ff @(posedge i_clk) begin
        if (do_push) begin
            r_q[r_wp] <= cmd_in;
        end
    end

endmodule

`default_nettype wire

@@ src/pba_back.sv @@
// Back end: free lists, break pointer, header memory and the request sequencer.
// Depends on pba_pkg and pow2_bucket_block_allocator_top_assert.svh.
`timescale 1ns / 1ps
`default_nettype none
`include "pow2_bucket_block_allocator_top_assert.svh"

module pba_back (
    input  wire                  i_clk,
    input  wire                  i_rst_n,
    input  wire                  i_cfg_we,
    input  wire                  i_cfg_idx,
    input  wire  [15:0]          i_cfg_wdata,
    input  wire                  i_cmd_valid,
    input  pba_pkg::t_cmd        i_cmd,
    output logic                 o_cmd_pop,
    input  wire                  i_res_room,
    output logic                 o_res_valid,
    output pba_pkg::t_res        o_res
);

    typedef enum logic [1:0] {
        S_IDLE,
        S_POP,
        S_FREE
    } t_state;

    t_state              r_state, n_state;
    pba_pkg::t_addr      r_break, n_break;
    pba_pkg::t_addr      r_limit, n_limit;
    pba_pkg::t_cls       r_cls, n_cls;
    pba_pkg::t_addr      r_usable, n_usable;
    pba_pkg::t_hdr_idx   r_hi, n_hi;
    pba_pkg::t_addr      r_list_heads [pba_pkg::SIZE_CLASSES];

    logic [15:0]         r_hdr [pba_pkg::HEADER_WORDS];
    logic [15:0]         r_rdata;
    logic                hdr_we;
    pba_pkg::t_hdr_idx   hdr_waddr;
    logic [15:0]         hdr_wdata;
    logic                hdr_re;
    pba_pkg::t_hdr_idx   hdr_raddr;

    pba_pkg::t_cls       rd_cls;
    logic                rd_bad;
    pba_pkg::t_cls       lh_sel;
    pba_pkg::t_addr      lh_rd;
    logic                lh_we;
    pba_pkg::t_addr      lh_wdata;
    pba_pkg::t_brk       carve_next;
    pba_pkg::t_addr      carve_usable;

    assign rd_cls       = pba_pkg::t_cls'(r_rdata);
    assign rd_bad       = (r_rdata >= 16'(pba_pkg::SIZE_CLASSES));
    assign lh_sel       = (r_state == S_FREE) ? rd_cls :
                          (r_state == S_POP)  ? r_cls  : i_cmd.cls;
    assign lh_rd        = r_list_heads[lh_sel];
    assign carve_next   = {1'b0, r_break} + pba_pkg::class_bytes(i_cmd.cls)
                        + pba_pkg::t_brk'(pba_pkg::HDR_BYTES);
    assign carve_usable = r_break + pba_pkg::t_addr'(pba_pkg::HDR_BYTES);

    always_comb begin
        n_state     = r_state;
        n_break     = r_break;
        n_limit     = r_limit;
        n_cls       = r_cls;
        n_usable    = r_usable;
        n_hi        = r_hi;
        hdr_we      = 1'b0;
        hdr_waddr   = r_hi;
        hdr_wdata   = '0;
        hdr_re      = 1'b0;
        hdr_raddr   = r_hi;
        lh_we       = 1'b0;
        lh_wdata    = r_usable;
        o_cmd_pop   = 1'b0;
        o_res_valid = 1'b0;
        o_res.addr   = '0;
        o_res.status = pba_pkg::ST_OK;

        unique case (r_state)
            S_IDLE: begin
                if (i_cmd_valid && i_res_room) begin
                    o_cmd_pop = 1'b1;
                    if (i_cmd.op == pba_pkg::OP_FREE) begin
                        hdr_re    = 1'b1;
                        hdr_raddr = pba_pkg::hdr_index(i_cmd.addr);
                        n_hi      = pba_pkg::hdr_index(i_cmd.addr);
                        n_usable  = i_cmd.addr;
                        n_state   = S_FREE;
                    end else if (!i_cmd.size_ok) begin
                        o_res_valid  = 1'b1;
                        o_res.status = pba_pkg::ST_BAD_SIZE;
                    end else if (lh_rd != '0) begin
                        // pop: fetch the next link from the head block's header
                        hdr_re    = 1'b1;
                        hdr_raddr = pba_pkg::hdr_index(lh_rd);
                        n_hi      = pba_pkg::hdr_index(lh_rd);
                        n_usable  = lh_rd;
                        n_cls     = i_cmd.cls;
                        n_state   = S_POP;
                    end else if (carve_next >= {1'b0, r_limit}) begin
                        o_res_valid  = 1'b1;
                        o_res.status = pba_pkg::ST_EXHAUSTED;
                    end else begin
                        n_break     = pba_pkg::t_addr'(carve_next);
                        hdr_we      = 1'b1;
                        hdr_waddr   = pba_pkg::hdr_index(carve_usable);
                        hdr_wdata   = 16'(i_cmd.cls);
                        o_res_valid = 1'b1;
                        o_res.addr  = carve_usable;
                    end
                end
            end
            S_POP: begin
                lh_we       = 1'b1;
                lh_wdata    = r_rdata;
                hdr_we      = 1'b1;
                hdr_wdata   = 16'(r_cls);
                o_res_valid = 1'b1;
                o_res.addr  = r_usable;
                n_state     = S_IDLE;
            end
            S_FREE: begin
                o_res_valid = 1'b1;
                if (rd_bad) begin
                    o_res.status = pba_pkg::ST_BAD_SIZE;
                end else begin
                    hdr_we    = 1'b1;
                    hdr_wdata = lh_rd;
                    lh_we     = 1'b1;
                    lh_wdata  = r_usable;
                end
                n_state = S_IDLE;
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase

        if (i_cfg_we) begin
            if (i_cfg_idx == pba_pkg::CFG_HEAP_BASE) begin
                n_break = i_cfg_wdata;
            end else begin
                n_limit = i_cfg_wdata;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_break <= '0;
            r_limit <= '1;
            for (int i = 0; i < pba_pkg::SIZE_CLASSES; i++) begin
                r_list_heads[i] <= '0;
            end
        end else begin
            r_state <= n_state;
            r_break <= n_break;
            r_limit <= n_limit;
            if (lh_we) begin
                r_list_heads[lh_sel] <= lh_wdata;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        r_cls    <= n_cls;
        r_usable <= n_usable;
        r_hi     <= n_hi;
    end

    // header memory
    always_ff @(posedge i_clk) begin
        if (hdr_we) begin
            r_hdr[hdr_waddr] <= hdr_wdata;
        end
    end

    always_ff @(posedge i_clk) begin
        if (hdr_re) begin
            r_rdata <= r_hdr[hdr_raddr];
        end
    end

    `PBA_ASSERT_NOW(a_busy_delivers, r_state != S_IDLE, o_res_valid && !o_cmd_pop)
    `PBA_ASSERT_NOW(a_err_zero_addr, o_res_valid && o_res.status != pba_pkg::ST_OK,
                    o_res.addr == '0)
    `PBA_ASSERT_NEXT(a_read_then_use, hdr_re, r_state == S_POP || r_state == S_FREE)

endmodule

`default_nettype wire

@@ src/pba_res_q.sv @@
// Result queue: holds finished results until the consumer pops them.
// Depends on pba_pkg.
`timescale 1ns / 1ps
`default_nettype none

module pba_res_q (
    input  wire                  i_clk,
    input  wire                  i_rst_n,
    input  wire                  i_push,
    input  pba_pkg::t_res        i_res,
    output logic                 o_room,
    output logic                 o_empty,
    output pba_pkg::t_res        o_res,
    input  wire                  i_pop
);

    pba_pkg::t_res  r_q [pba_pkg::QDEPTH];
    pba_pkg::t_qptr r_wp, n_wp;
    pba_pkg::t_qptr r_rp, n_rp;
    pba_pkg::t_qcnt r_cnt, n_cnt;
    logic           do_push;
    logic           do_pop;

    assign o_room  = (r_cnt != pba_pkg::t_qcnt'(pba_pkg::QDEPTH));
    assign o_empty = (r_cnt == '0);
    assign o_res   = r_q[r_rp];
    assign do_push = i_push && o_room;
    assign do_pop  = i_pop && !o_empty;

    always_comb begin
        n_wp  = r_wp;
        n_rp  = r_rp;
        n_cnt = r_cnt;
        if (do_push) begin
            n_wp = (r_wp == pba_pkg::t_qptr'(pba_pkg::QDEPTH - 1)) ? '0 : r_wp + 1'b1;
        end
        if (do_pop) begin
            n_rp = (r_rp == pba_pkg::t_qptr'(pba_pkg::QDEPTH - 1)) ? '0 : r_rp + 1'b1;
        end
        if (do_push && !do_pop) begin
            n_cnt = r_cnt + 1'b1;
        end else if (do_pop && !do_push) begin
            n_cnt = r_cnt - 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wp  <= '0;
            r_rp  <= '0;
            r_cnt <= '0;
        end else begin
            r_wp  <= n_wp;
            r_rp  <= n_rp;
            r_cnt <= n_cnt;
        end
    end

    always_ff @(posedge i_clk) begin
        if (do_push) begin
            r_q[r_wp] <= i_res;
        end
    end

endmodule

`default_nettype wire

@@ src/pow2_bucket_block_allocator_top.sv @@
// Pow2 bucket block allocator, top level: front classifier, back sequencer, result queue.
// Depends on pba_pkg, pba_front, pba_back and pba_res_q.
//
// Allocates blocks of 8 to 1024 bytes in eight power-of-two classes, each with its
// own LIFO free list, carving new blocks with a 4-byte header from a rising break
// pointer. Requests enter a two-deep queue and run one at a time in the back end:
// an allocate with a bad size, or one that carves or finds the heap exhausted,
// finishes in S_IDLE; an allocate that pops a free list and every free also goes through
// S_POP or S_FREE for the registered read of the header memory before the list head
// update. Results wait in a two-deep queue. Writing heap_base also reloads the break.
`timescale 1ns / 1ps
`default_nettype none

module pow2_bucket_block_allocator_top (
    input  wire          i_clk,
    input  wire          i_rst_n,
    input  wire          i_cfg_we,
    input  wire          i_cfg_idx,
    input  wire  [15:0]  i_cfg_wdata,
    input  wire          i_push,
    output logic         o_full,
    input  wire          i_opcode,
    input  wire  [15:0]  i_request_size,
    input  wire  [15:0]  i_release_address,
    output logic         o_empty,
    input  wire          i_pop,
    output logic [15:0]  o_block_address,
    output logic [1:0]   o_status
);

    logic          cmd_valid;
    pba_pkg::t_cmd cmd;
    logic          cmd_pop;
    logic          res_room;
    logic          res_valid;
    pba_pkg::t_res res_in;
    pba_pkg::t_res res_out;

    pba_front u_front (
        .i_clk             (i_clk),
        .i_rst_n           (i_rst_n),
        .i_push            (i_push),
        .o_full            (o_full),
        .i_opcode          (i_opcode),
        .i_request_size    (i_request_size),
        .i_release_address (i_release_address),
        .o_cmd_valid       (cmd_valid),
        .o_cmd             (cmd),
        .i_cmd_pop         (cmd_pop)
    );

    pba_back u_back (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_idx   (i_cfg_idx),
        .i_cfg_wdata (i_cfg_wdata),
        .i_cmd_valid (cmd_valid),
        .i_cmd       (cmd),
        .o_cmd_pop   (cmd_pop),
        .i_res_room  (res_room),
        .o_res_valid (res_valid),
        .o_res       (res_in)
    );

    pba_res_q u_res_q (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (res_valid),
        .i_res   (res_in),
        .o_room  (res_room),
        .o_empty (o_empty),
        .o_res   (res_out),
        .i_pop   (i_pop)
    );

    assign o_block_address = res_out.addr;
    assign o_status        = 2'(res_out.status);

endmodule

`default_nettype wire

@@ tb/testbench.sv @@
// Self-checking testbench for pow2_bucket_block_allocator_top.
// Depends on pba_pkg. A directed table runs first, then random phases under several
// heap windows. Typed rows check the table, others an in-bench allocator predictor.
`timescale 1ns / 1ps

module testbench;

    localparam int MAX_REQ        = pba_pkg::MIN_BLOCK << (pba_pkg::SIZE_CLASSES - 1);
    localparam int HOLD_CYCLES    = 300;
    localparam int WATCHDOG_LIMIT = 5000;
    localparam int DRAIN_CYCLES   = 20;
    localparam int FREED_KEEP     = 64;

    typedef struct packed {
        pba_pkg::t_addr   addr;
        pba_pkg::t_status status;
    } t_alloc_result;

    typedef enum logic [1:0] {
        ROW_ALLOC,
        ROW_FREE,
        ROW_BASE,
        ROW_LIMIT
    } t_row_kind;

    typedef struct packed {
        t_row_kind        kind;
        logic [15:0]      arg;
        logic             typed;
        pba_pkg::t_addr   exp_addr;
        pba_pkg::t_status exp_status;
    } t_row;

    typedef struct packed {
        pba_pkg::t_addr base;
        pba_pkg::t_addr limit;
        logic [15:0]    count;
        logic           stress;
    } t_phase;

    localparam t_row DIRECTED [27] = '{
        '{ROW_ALLOC, 16'd0,     1'b1, 16'd0,    pba_pkg::ST_BAD_SIZE},
        '{ROW_ALLOC, 16'd1025,  1'b1, 16'd0,    pba_pkg::ST_BAD_SIZE},
        '{ROW_ALLOC, 16'hFFFF,  1'b1, 16'd0,    pba_pkg::ST_BAD_SIZE},
        '{ROW_ALLOC, 16'd1,     1'b1, 16'd4,    pba_pkg::ST_OK},
        '{ROW_ALLOC, 16'd8,     1'b1, 16'd16,   pba_pkg::ST_OK},
        '{ROW_ALLOC, 16'd9,     1'b0, 16'd0,    pba_pkg::ST_OK},
        '{ROW_ALLOC, 16'd1024,  1'b0, 16'd0,    pba_pkg::ST_OK},
        '{ROW_ALLOC, 16'd513,   1'b0, 16'd0,    pba_pkg::ST_OK},
        '{ROW_FREE,  16'd4,     1'b1, 16'd0,    pba_pkg::ST_OK},
        '{ROW_FREE,  16'd16,    1'b1, 16'd0,    pba_pkg::ST_OK},
        '{ROW_ALLOC, 16'd5,     1'b1, 16'd16,   pba_pkg::ST_OK},
        '{ROW_ALLOC, 16'd8,     1'b1, 16'd4,    pba_pkg::ST_OK},
        '{ROW_FREE,  16'd48,    1'b1, 16'd0,    pba_pkg::ST_OK},
        '{ROW_FREE,  16'd1076,  1'b1, 16'd0,    pba_pkg::ST_OK},
        // double free: header now holds a list link, not a class
        '{ROW_FREE,  16'd1076,  1'b1, 16'd0,    pba_pkg::ST_BAD_SIZE},
        '{ROW_ALLOC, 16'd1000,  1'b1, 16'd1076, pba_pkg::ST_OK},
        '{ROW_LIMIT, 16'd2200,  1'b0, 16'd0,    pba_pkg::ST_OK},
        '{ROW_ALLOC, 16'd64,    1'b0, 16'd0,    pba_pkg::ST_OK},
        '{ROW_ALLOC, 16'd64,    1'b1, 16'd0,    pba_pkg::ST_EXHAUSTED},
        // free list still serves once the break is stuck
        '{ROW_ALLOC, 16'd1024,  1'b1, 16'd48,   pba_pkg::ST_OK},
        '{ROW_ALLOC, 16'd2,     1'b0, 16'd0,    pba_pkg::ST_OK},
        '{ROW_ALLOC, 16'd8,     1'b0, 16'd0,    pba_pkg::ST_OK},
        '{ROW_ALLOC, 16'd8,     1'b1, 16'd0,    pba_pkg::ST_EXHAUSTED},
        '{ROW_LIMIT, 16'hFFFF,  1'b0, 16'd0,    pba_pkg::ST_OK},
        '{ROW_BASE,  16'hFFFF,  1'b0, 16'd0,    pba_pkg::ST_OK},
        '{ROW_ALLOC, 16'd1,     1'b1, 16'd0,    pba_pkg::ST_EXHAUSTED},
        '{ROW_ALLOC, 16'd2000,  1'b1, 16'd0,    pba_pkg::ST_BAD_SIZE}
    };

    localparam t_phase PHASES [5] = '{
        '{16'h0000, 16'h0400, 16'd300, 1'b0},
        '{16'hF000, 16'hFFFF, 16'd300, 1'b0},
        '{16'h0103, 16'h2000, 16'd300, 1'b0},
        '{16'h0000, 16'h0000, 16'd100, 1'b0},
        '{16'h0000, 16'hFFFF, 16'd850, 1'b1}
    };

    logic                i_clk             = 1'b0;
    logic                i_rst_n           = 1'b0;
    logic                i_cfg_we          = 1'b0;
    pba_pkg::t_cfg_idx   i_cfg_idx         = pba_pkg::CFG_HEAP_BASE;
    logic [15:0]         i_cfg_wdata       = 16'd0;
    logic                i_push            = 1'b0;
    logic                i_opcode          = 1'b0;
    logic [15:0]         i_request_size    = 16'd0;
    logic [15:0]         i_release_address = 16'd0;
    logic                i_pop             = 1'b0;
    logic                o_full;
    logic                o_empty;
    logic [15:0]         o_block_address;
    logic [1:0]          o_status;

    pow2_bucket_block_allocator_top uut (
        .i_clk             (i_clk),
        .i_rst_n           (i_rst_n),
        .i_cfg_we          (i_cfg_we),
        .i_cfg_idx         (i_cfg_idx),
        .i_cfg_wdata       (i_cfg_wdata),
        .i_push            (i_push),
        .o_full            (o_full),
        .i_opcode          (i_opcode),
        .i_request_size    (i_request_size),
        .i_release_address (i_release_address),
        .o_empty           (o_empty),
        .i_pop             (i_pop),
        .o_block_address   (o_block_address),
        .o_status          (o_status)
    );

    always begin
        #5 i_clk = 1'b1;
        #5 i_clk = 1'b0;
    end

    // allocator state as predicted
    int             heap_base  = 0;
    int             heap_limit = 65535;
    int             brk        = 0;
    pba_pkg::t_addr free_head [pba_pkg::SIZE_CLASSES];
    logic [15:0]    header_word [pba_pkg::HEADER_WORDS];
    bit             header_set [pba_pkg::HEADER_WORDS];

    // stimulus bookkeeping
    pba_pkg::t_addr live_blocks[$];
    pba_pkg::t_addr freed_blocks[$];
    pba_pkg::t_addr carved_blocks[$];
    t_alloc_result  pending_results[$];

    bit send_idle = 1'b1;
    bit recv_idle = 1'b1;
    int holds_asked = 0;
    int fails = 0;
    int quiet_cycles = 0;
    int n_carved = 0, n_reused = 0, n_exhausted = 0, n_bad_size = 0;
    int n_freed = 0, n_free_rejected = 0;

    initial begin
        foreach (free_head[c]) free_head[c] = '0;
    end

    function automatic int header_slot(input pba_pkg::t_addr usable);
        pba_pkg::t_addr blk;
        blk = usable - pba_pkg::t_addr'(pba_pkg::HDR_BYTES);
        return (int'(blk) / 4) % pba_pkg::HEADER_WORDS;
    endfunction

    task automatic predict_request(input pba_pkg::t_op op, input logic [15:0] size,
                                   input pba_pkg::t_addr addr, output t_alloc_result res);
        int cls;
        int slot;
        int next_brk;
        res.addr   = '0;
        res.status = pba_pkg::ST_OK;
        if (op == pba_pkg::OP_ALLOC) begin
            cls = -1;
            if (size != 0)
                for (int c = pba_pkg::SIZE_CLASSES - 1; c >= 0; c--)
                    if ((pba_pkg::MIN_BLOCK << c) >= int'(size)) cls = c;
            if (cls < 0) begin
                res.status = pba_pkg::ST_BAD_SIZE;
                n_bad_size++;
            end else if (free_head[cls] != 0) begin
                slot = header_slot(free_head[cls]);
                res.addr = free_head[cls];
                free_head[cls] = header_word[slot];
                header_word[slot] = 16'(cls);
                n_reused++;
            end else begin
                next_brk = brk + (pba_pkg::MIN_BLOCK << cls) + pba_pkg::HDR_BYTES;
                if (next_brk >= heap_limit) begin
                    res.status = pba_pkg::ST_EXHAUSTED;
                    n_exhausted++;
                end else begin
                    res.addr = pba_pkg::t_addr'(brk + pba_pkg::HDR_BYTES);
                    slot = header_slot(res.addr);
                    header_word[slot] = 16'(cls);
                    header_set[slot] = 1'b1;
                    brk = next_brk;
                    carved_blocks.push_back(res.addr);
                    n_carved++;
                end
            end
            if (res.status == pba_pkg::ST_OK) live_blocks.push_back(res.addr);
        end else begin
            slot = header_slot(addr);
            if (header_word[slot] >= pba_pkg::SIZE_CLASSES) begin
                res.status = pba_pkg::ST_BAD_SIZE;
                n_free_rejected++;
            end else begin
                cls = int'(header_word[slot]);
                header_word[slot] = free_head[cls];
                free_head[cls] = addr;
                freed_blocks.push_back(addr);
                if (freed_blocks.size() > FREED_KEEP) void'(freed_blocks.pop_front());
                n_freed++;
            end
        end
    endtask

    // allocates and frees; frees are mostly of live blocks, some double frees and stray addresses with a header
    task automatic pick_request(output pba_pkg::t_op op, output logic [15:0] size,
                                output pba_pkg::t_addr addr);
        int k;
        int c;
        int i;
        int cls;
        pba_pkg::t_addr cand;
        size = 16'($urandom);
        addr = 16'($urandom);
        k = $urandom_range(0, 99);
        if (k < 55 || carved_blocks.size() == 0) begin
            op = pba_pkg::OP_ALLOC;
            k = $urandom_range(0, 99);
            c = $urandom_range(0, pba_pkg::SIZE_CLASSES - 1);
            if (k < 3)
                size = 16'd0;
            else if (k < 8)
                size = 16'($urandom_range(MAX_REQ + 1, 65535));
            else if (k < 16)
                size = 16'(pba_pkg::MIN_BLOCK << c);
            else
                size = 16'($urandom_range(c == 0 ? 1 : (pba_pkg::MIN_BLOCK << (c - 1)) + 1,
                                          pba_pkg::MIN_BLOCK << c));
            cls = -1;
            for (int j = pba_pkg::SIZE_CLASSES - 1; j >= 0; j--)
                if ((pba_pkg::MIN_BLOCK << j) >= int'(size)) cls = j;
            // a corrupted list whose head has no header is never popped
            if (size != 0 && cls >= 0 && free_head[cls] != 0
                    && !header_set[header_slot(free_head[cls])])
                size = 16'd0;
        end else begin
            op = pba_pkg::OP_FREE;
            k = $urandom_range(0, 99);
            i = $urandom_range(0, carved_blocks.size() - 1);
            if (k < 80 && live_blocks.size() > 0) begin
                i = $urandom_range(0, live_blocks.size() - 1);
                addr = live_blocks[i];
                live_blocks.delete(i);
            end else if (k < 90 && freed_blocks.size() > 0) begin
                addr = freed_blocks[$urandom_range(0, freed_blocks.size() - 1)];
            end else if (k < 97) begin
                cand = carved_blocks[i] + pba_pkg::t_addr'($urandom_range(0, 3));
                addr = header_set[header_slot(cand)] ? cand : carved_blocks[i];
            end else if (!header_set[header_slot(addr)]) begin
                addr = carved_blocks[i];
            end
        end
    endtask

    task automatic issue_request(input pba_pkg::t_op op, input logic [15:0] size,
                                 input pba_pkg::t_addr addr,
                                 input bit typed, input t_alloc_result typed_res);
        t_alloc_result res;
        @(negedge i_clk);
        while (send_idle && $urandom_range(0, 99) < 38) begin
            i_push = 1'b0;
            @(negedge i_clk);
        end
        i_opcode          = op;
        i_request_size    = size;
        i_release_address = addr;
        i_push            = 1'b1;
        do @(posedge i_clk); while (o_full !== 1'b0);
        predict_request(op, size, addr, res);
        pending_results.push_back(typed ? typed_res : res);
    endtask

    task automatic wait_drained();
        @(negedge i_clk);
        i_push = 1'b0;
        while (pending_results.size() != 0) @(negedge i_clk);
    endtask

    task automatic write_reg(input pba_pkg::t_cfg_idx sel, input pba_pkg::t_addr value);
        wait_drained();
        i_cfg_we    = 1'b1;
        i_cfg_idx   = sel;
        i_cfg_wdata = value;
        @(negedge i_clk);
        i_cfg_we = 1'b0;
        if (sel == pba_pkg::CFG_HEAP_BASE) begin
            heap_base = int'(value);
            brk       = int'(value);
        end else begin
            heap_limit = int'(value);
        end
    endtask

    // result side: random pop gaps, plus long hold-offs on request
    initial begin
        int hold_left;
        int holds_served;
        hold_left    = 0;
        holds_served = 0;
        forever begin
            @(negedge i_clk);
            if (holds_served != holds_asked) begin
                holds_served++;
                hold_left = HOLD_CYCLES;
            end
            if (hold_left > 0) begin
                hold_left--;
                i_pop = 1'b0;
            end else begin
                i_pop = !(recv_idle && $urandom_range(0, 99) < 38);
            end
        end
    end

    always @(posedge i_clk) begin
        t_alloc_result want;
        if (i_rst_n && i_pop && o_empty === 1'b0) begin
            if (pending_results.size() == 0) begin
                $error("result with no request outstanding: block_address %h status %0d",
                       o_block_address, o_status);
                fails++;
            end else begin
                want = pending_results.pop_front();
                if (o_block_address !== want.addr) begin
                    $error("block_address: expected %h, got %h", want.addr, o_block_address);
                    fails++;
                end
                if (o_status !== want.status) begin
                    $error("status: expected %0d, got %0d", want.status, o_status);
                    fails++;
                end
            end
        end
        if ((i_push && o_full === 1'b0) || (i_pop && o_empty === 1'b0))
            quiet_cycles = 0;
        else
            quiet_cycles++;
        if (quiet_cycles >= WATCHDOG_LIMIT) begin
            $display("watchdog: no request or result moved in %0d cycles", WATCHDOG_LIMIT);
            $display("CHECK FAILED");
            $finish;
        end
    end

    initial begin
        t_alloc_result  typed_res;
        pba_pkg::t_op   op;
        logic [15:0]    size;
        pba_pkg::t_addr addr;
        repeat (10) @(negedge i_clk);
        i_rst_n = 1'b1;

        foreach (DIRECTED[r]) begin
            typed_res.addr   = DIRECTED[r].exp_addr;
            typed_res.status = DIRECTED[r].exp_status;
            case (DIRECTED[r].kind)
                ROW_BASE:  write_reg(pba_pkg::CFG_HEAP_BASE, DIRECTED[r].arg);
                ROW_LIMIT: write_reg(pba_pkg::CFG_HEAP_LIMIT, DIRECTED[r].arg);
                ROW_ALLOC: issue_request(pba_pkg::OP_ALLOC, DIRECTED[r].arg, 16'($urandom),
                                         DIRECTED[r].typed, typed_res);
                default:   issue_request(pba_pkg::OP_FREE, 16'($urandom), DIRECTED[r].arg,
                                         DIRECTED[r].typed, typed_res);
            endcase
        end

        foreach (PHASES[p]) begin
            write_reg(pba_pkg::CFG_HEAP_BASE, PHASES[p].base);
            write_reg(pba_pkg::CFG_HEAP_LIMIT, PHASES[p].limit);
            for (int n = 0; n < int'(PHASES[p].count); n++) begin
                if (PHASES[p].stress) begin
                    if (n == 0) begin
                        send_idle = 1'b0;
                        recv_idle = 1'b0;
                    end else if (n == 200) begin
                        send_idle = 1'b1;
                        recv_idle = 1'b1;
                    end else if (n == 300) begin
                        // back-to-back requests into a stalled result side
                        holds_asked++;
                        send_idle = 1'b0;
                    end else if (n == 340) begin
                        send_idle = 1'b1;
                    end else if (n == 600) begin
                        wait_drained();
                    end
                end
                pick_request(op, size, addr);
                issue_request(op, size, addr, 1'b0, typed_res);
            end
        end

        wait_drained();
        repeat (DRAIN_CYCLES) @(posedge i_clk);
        $display("allocations: %0d carved, %0d from free lists, %0d exhausted, %0d bad sizes",
                 n_carved, n_reused, n_exhausted, n_bad_size);
        $display("frees: %0d accepted, %0d rejected on header; %0d heap windows",
                 n_freed, n_free_rejected, $size(PHASES) + 1);
        if (fails == 0)
            $display("CHECK OK");
        else
            $display("CHECK FAILED");
        $finish;
    end

endmodule
